// ===== hdl/swrl_pkg.sv =====
// Shared types and constants of the sliding-window rate limiter.
// Depends on nothing; every other file but swrl_ram uses it.
package swrl_pkg;

  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_VIOL  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    RS_OK      = 3'd0,
    RS_BANNED  = 3'd1,
    RS_PER_SEC = 3'd2,
    RS_PER_MIN = 3'd3,
    RS_VIOL    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_PSL      = 2'd0,
    REG_PML      = 2'd1,
    REG_BAN_LEN  = 2'd2,
    REG_VIOL_THR = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_DECIDE = 3'b100
  } state_e;

  localparam logic [31:0] SECOND_MS = 32'd1000;
  localparam logic [31:0] MINUTE_MS = 32'd60000;
  localparam logic [7:0]  VIOL_MAX  = 8'd255;

  localparam logic [6:0]  PSL_RESET      = 7'd10;
  localparam logic [6:0]  PML_RESET      = 7'd60;
  localparam logic [26:0] BAN_LEN_RESET  = 27'd300000;
  localparam logic [7:0]  VIOL_THR_RESET = 8'd5;

  typedef struct packed {
    op_e         op;
    logic [3:0]  client;
    logic [31:0] time_ms;
  } req_t;

  typedef struct packed {
    logic [6:0]  psl;
    logic [6:0]  pml;
    logic [26:0] ban_len;
    logic [7:0]  thr;
  } cfg_t;

endpackage

// ===== hdl/swrl_if.sv =====
// Request and response channel interfaces of the rate limiter.
// Depends on swrl_pkg for the status type.
interface swrl_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  client;
  logic [31:0] time_ms;

  modport source (output valid, op, client, time_ms, input ready);
  modport sink   (input valid, op, client, time_ms, output ready);
endinterface

interface swrl_rsp_if;
  import swrl_pkg::*;
  logic       valid;
  logic       ready;
  logic       accepted;
  status_e    status;
  logic [6:0] ops_in_minute;
  logic       now_banned;

  modport source (output valid, accepted, status, ops_in_minute, now_banned, input ready);
  modport sink   (input valid, accepted, status, ops_in_minute, now_banned, output ready);
endinterface

// ===== hdl/swrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ===== hdl/swrl_front.sv =====
// Front end: accepts requests and holds them in a two-entry queue.
// Depends on swrl_pkg and swrl_req_if.
module swrl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  swrl_req_if.sink           req,
  output logic               q_valid_o,
  output swrl_pkg::req_t     q_data_o,
  input  logic               q_ready_i
);
  import swrl_pkg::*;

  req_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign req.ready = (fill_q != 2'd2);
  assign q_valid_o = (fill_q != 2'd0);
  assign q_data_o  = slot_q[rd_ptr_q];
  assign push      = req.valid && req.ready;
  assign pop       = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{op: op_e'(req.op), client: req.client, time_ms: req.time_ms};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end
endmodule

// ===== hdl/swrl_back.sv =====
// Back end: per-client state, log walk over the timestamp RAM, result register.
// Depends on swrl_pkg, swrl_rsp_if and swrl_ram.
module swrl_back #(
  parameter int NUM_CLIENTS = 16,
  parameter int LOG_DEPTH   = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  swrl_pkg::req_t q_data_i,
  output logic           q_ready_o,
  input  swrl_pkg::cfg_t cfg_i,
  swrl_rsp_if.source     rsp
);
  import swrl_pkg::*;

  localparam int CIDX_W    = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int IDX_W     = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int CMP_W     = (CNT_W > 7) ? CNT_W : 7;
  localparam int RAM_DEPTH = NUM_CLIENTS * (2 ** IDX_W);
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // per-client state
  logic [CNT_W-1:0] cnt_tab_q  [NUM_CLIENTS];
  logic [7:0]       viol_tab_q [NUM_CLIENTS];
  logic             ban_tab_q  [NUM_CLIENTS];
  logic [31:0]      exp_tab_q  [NUM_CLIENTS];

  state_e           state_q;
  logic [CIDX_W-1:0] cur_c_q;
  logic [31:0]      now_q;
  logic [CNT_W-1:0] cnt_q, rd_idx_q, kept_q, recent_q;
  logic             pend_q;

  logic             out_valid_q, out_acc_q, out_ban_q;
  status_e          out_status_q;
  logic [6:0]       out_cnt_q;

  logic [CIDX_W-1:0] q_cidx;
  logic             pop, take;
  logic [7:0]       viol_inc;
  logic [31:0]      ban_diff;
  logic [31:0]      t, age;
  logic             keep, fresh;
  logic [CMP_W-1:0] cap, psl_w, recent_w, kept_w;
  logic             rej_sec, rej_min;

  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;

  // fold the client index into range
  always_comb begin
    q_cidx = '0;
    for (int k = 0; k < 16; k++) begin
      if (q_data_i.client == 4'(k)) q_cidx = CIDX_W'(k % NUM_CLIENTS);
    end
  end

  assign take      = out_valid_q && rsp.ready;
  assign q_ready_o = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
  assign pop       = q_valid_i && q_ready_o;

  assign viol_inc = (viol_tab_q[q_cidx] == VIOL_MAX) ? VIOL_MAX : viol_tab_q[q_cidx] + 8'd1;
  assign ban_diff = q_data_i.time_ms - exp_tab_q[q_cidx];

  assign t     = ram_rdata;
  assign age   = now_q - t;
  assign keep  = (age <= MINUTE_MS);
  assign fresh = (age <= SECOND_MS);

  assign psl_w    = CMP_W'(cfg_i.psl);
  assign cap      = (CMP_W'(cfg_i.pml) > CMP_W'(LOG_DEPTH)) ? CMP_W'(LOG_DEPTH)
                                                            : CMP_W'(cfg_i.pml);
  assign recent_w = CMP_W'(recent_q);
  assign kept_w   = CMP_W'(kept_q);
  assign rej_sec  = (recent_w >= psl_w);
  assign rej_min  = (kept_w >= cap);

  assign ram_re    = (state_q == ST_WALK) && (rd_idx_q < cnt_q);
  assign ram_raddr = RAM_AW'({cur_c_q, rd_idx_q[IDX_W-1:0]});
  assign ram_waddr = RAM_AW'({cur_c_q, kept_q[IDX_W-1:0]});

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = t;
    if (state_q == ST_WALK && pend_q && keep) begin
      ram_we = 1'b1;
    end else if (state_q == ST_DECIDE && !rej_sec && !rej_min) begin
      ram_we    = 1'b1;
      ram_wdata = now_q;
    end
  end

  swrl_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_log (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_c_q <= q_cidx;
      now_q   <= q_data_i.time_ms;
      cnt_q   <= cnt_tab_q[q_cidx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_idx_q     <= '0;
      kept_q       <= '0;
      recent_q     <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_acc_q    <= 1'b0;
      out_ban_q    <= 1'b0;
      out_status_q <= RS_OK;
      out_cnt_q    <= '0;
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        cnt_tab_q[i]  <= '0;
        viol_tab_q[i] <= '0;
        ban_tab_q[i]  <= 1'b0;
        exp_tab_q[i]  <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            if (q_data_i.op == OP_VIOL) begin
              viol_tab_q[q_cidx] <= viol_inc;
              out_valid_q  <= 1'b1;
              out_acc_q    <= 1'b0;
              out_status_q <= RS_VIOL;
              out_cnt_q    <= 7'(cnt_tab_q[q_cidx]);
              if (viol_inc >= cfg_i.thr) begin
                ban_tab_q[q_cidx] <= 1'b1;
                exp_tab_q[q_cidx] <= q_data_i.time_ms + {5'b0, cfg_i.ban_len};
                out_ban_q <= 1'b1;
              end else begin
                out_ban_q <= ban_tab_q[q_cidx];
              end
            end else if (ban_tab_q[q_cidx] && ban_diff[31]) begin
              out_valid_q  <= 1'b1;
              out_acc_q    <= 1'b0;
              out_status_q <= RS_BANNED;
              out_cnt_q    <= 7'(cnt_tab_q[q_cidx]);
              out_ban_q    <= 1'b1;
            end else begin
              // lift an expired ban and start the walk
              if (ban_tab_q[q_cidx]) begin
                ban_tab_q[q_cidx]  <= 1'b0;
                viol_tab_q[q_cidx] <= '0;
              end
              out_valid_q <= 1'b0;
              rd_idx_q <= '0;
              kept_q   <= '0;
              recent_q <= '0;
              pend_q   <= 1'b0;
              state_q  <= ST_WALK;
            end
          end else if (take) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_WALK: begin
          if (ram_re) rd_idx_q <= rd_idx_q + CNT_W'(1);
          pend_q <= ram_re;
          if (pend_q && keep) begin
            kept_q <= kept_q + CNT_W'(1);
            if (fresh) recent_q <= recent_q + CNT_W'(1);
          end
          if (!ram_re && !pend_q) state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          out_valid_q <= 1'b1;
          out_ban_q   <= 1'b0;
          if (rej_sec || rej_min) begin
            cnt_tab_q[cur_c_q] <= kept_q;
            out_acc_q    <= 1'b0;
            out_status_q <= rej_sec ? RS_PER_SEC : RS_PER_MIN;
            out_cnt_q    <= 7'(kept_q);
          end else begin
            cnt_tab_q[cur_c_q] <= kept_q + CNT_W'(1);
            out_acc_q    <= 1'b1;
            out_status_q <= RS_OK;
            out_cnt_q    <= 7'(kept_q + CNT_W'(1));
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.accepted      = out_acc_q;
  assign rsp.status        = out_status_q;
  assign rsp.ops_in_minute = out_cnt_q;
  assign rsp.now_banned    = out_ban_q;

`ifndef SYNTHESIS
  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_valid_q)
    else $error("result pending while a check is in progress");
  a_compact_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && pend_q) |-> (kept_q < rd_idx_q))
    else $error("compaction write overtakes the read pointer");
  a_decide_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("decision did not produce a result");
`endif
endmodule

// ===== hdl/sliding_window_rate_limiter_core.sv =====
// Top level of the sliding-window rate limiter: APB register file, front queue, back end.
// Depends on swrl_pkg, swrl_if, swrl_front, swrl_back and swrl_ram.
//
// Each request names a client and a millisecond time. A violation request
// and a check on a client still under ban are answered from the idle state.
// Any other check walks the client's timestamp log one entry per cycle
// through the log RAM's single read port, compacting it in place; the
// back end then decides in ST_DECIDE and loads the result register. A
// client's log holds at most LOG_DEPTH entries. The back end takes the
// next request once it is idle again and its result register is free or
// being read. A two-entry request queue keeps accepting, until both entries
// are full, while the back end works, and a result register holds each
// response until it is taken. Registers (byte address 4*i): per-second limit,
// per-minute limit (capped at LOG_DEPTH), ban length in ms, violations to ban.
// Write them only while the block is idle. Log RAM contents need no clearing.
module sliding_window_rate_limiter_core #(
  parameter int NUM_CLIENTS = 16,
  parameter int LOG_DEPTH   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swrl_req_if.sink    req,
  swrl_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swrl_pkg::*;

  cfg_t   cfg_q;
  req_t   q_data;
  logic   q_valid, q_ready;
  logic   cfg_we;
  reg_e   reg_sel;

  // register file: write on the access cycle
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.psl     <= PSL_RESET;
      cfg_q.pml     <= PML_RESET;
      cfg_q.ban_len <= BAN_LEN_RESET;
      cfg_q.thr     <= VIOL_THR_RESET;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_PSL:      cfg_q.psl     <= pwdata[6:0];
        REG_PML:      cfg_q.pml     <= pwdata[6:0];
        REG_BAN_LEN:  cfg_q.ban_len <= pwdata[26:0];
        REG_VIOL_THR: cfg_q.thr     <= pwdata[7:0];
        default:      cfg_q         <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PSL:      prdata = {25'b0, cfg_q.psl};
      REG_PML:      prdata = {25'b0, cfg_q.pml};
      REG_BAN_LEN:  prdata = {5'b0, cfg_q.ban_len};
      REG_VIOL_THR: prdata = {24'b0, cfg_q.thr};
      default:      prdata = '0;
    endcase
  end

  // accept and queue requests
  swrl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_ready_i (q_ready)
  );

  // execute checks and violations, hold the result
  swrl_back #(
    .NUM_CLIENTS (NUM_CLIENTS),
    .LOG_DEPTH   (LOG_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_ready_o (q_ready),
    .cfg_i     (cfg_q),
    .rsp       (rsp)
  );
endmodule

// ===== tb/swrl_scoreboard.sv =====
// Scoreboard for the rate limiter: per-client log, ban state and expected responses.
// Depends on swrl_pkg for the operation and status codes, limits and reset values.
`timescale 1ns / 100ps

class swrl_scoreboard;
  typedef struct packed {
    logic       accepted;
    logic [2:0] status;
    logic [6:0] ops_in_minute;
    logic       now_banned;
  } rsp_t;

  localparam int NCLI  = 16;
  localparam int DEPTH = 64;

  logic [31:0] stamps[NCLI][$];
  logic [7:0]  viol_cnt[NCLI];
  logic        banned[NCLI];
  logic [31:0] ban_until[NCLI];

  logic [6:0]  psl;
  logic [6:0]  pml;
  logic [26:0] ban_len;
  logic [7:0]  thr;

  rsp_t pending_rsp[$];
  int   errors;
  int   checked;
  int   status_seen[5];

  function void clear();
    for (int c = 0; c < NCLI; c++) begin
      stamps[c].delete();
      viol_cnt[c] = '0;
      banned[c] = 1'b0;
      ban_until[c] = '0;
    end
    psl = swrl_pkg::PSL_RESET;
    pml = swrl_pkg::PML_RESET;
    ban_len = swrl_pkg::BAN_LEN_RESET;
    thr = swrl_pkg::VIOL_THR_RESET;
    errors = 0;
    checked = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  // Work out the response of one accepted request and queue it.
  function void note_request(logic op, logic [3:0] client, logic [31:0] now);
    rsp_t r;
    logic [31:0] keep[$];
    int recent;
    int cap;
    int c;
    c = client;
    r = '0;
    if (op == swrl_pkg::OP_VIOL) begin
      if (viol_cnt[c] != swrl_pkg::VIOL_MAX) viol_cnt[c]++;
      if (viol_cnt[c] >= thr) begin
        banned[c] = 1'b1;
        ban_until[c] = now + 32'(ban_len);
      end
      r.status = swrl_pkg::RS_VIOL;
      r.ops_in_minute = 7'(stamps[c].size());
      r.now_banned = banned[c];
      pending_rsp.push_back(r);
      return;
    end
    if (banned[c]) begin
      if (((now - ban_until[c]) >> 31) != 0) begin
        r.status = swrl_pkg::RS_BANNED;
        r.ops_in_minute = 7'(stamps[c].size());
        r.now_banned = 1'b1;
        pending_rsp.push_back(r);
        return;
      end
      banned[c] = 1'b0;
      viol_cnt[c] = '0;
    end
    recent = 0;
    foreach (stamps[c][i]) begin
      if (now - stamps[c][i] <= swrl_pkg::MINUTE_MS) begin
        keep.push_back(stamps[c][i]);
        if (now - stamps[c][i] <= swrl_pkg::SECOND_MS) recent++;
      end
    end
    stamps[c] = keep;
    cap = (pml > DEPTH) ? DEPTH : pml;
    if (recent >= psl) r.status = swrl_pkg::RS_PER_SEC;
    else if (stamps[c].size() >= cap) r.status = swrl_pkg::RS_PER_MIN;
    else begin
      stamps[c].push_back(now);
      r.accepted = 1'b1;
      r.status = swrl_pkg::RS_OK;
    end
    r.ops_in_minute = 7'(stamps[c].size());
    pending_rsp.push_back(r);
  endfunction

  function void check_response(rsp_t got);
    rsp_t want;
    if (pending_rsp.size() == 0) begin
      $display("%0t: unexpected response %h", $time, got);
      errors++;
      return;
    end
    want = pending_rsp.pop_front();
    checked++;
    if (want.status < 5) status_seen[want.status]++;
    if (got.accepted !== want.accepted) begin
      $display("%0t: accepted exp %0d got %0d", $time, want.accepted, got.accepted);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
      errors++;
    end
    if (got.ops_in_minute !== want.ops_in_minute) begin
      $display("%0t: ops_in_minute exp %0d got %0d", $time, want.ops_in_minute,
               got.ops_in_minute);
      errors++;
    end
    if (got.now_banned !== want.now_banned) begin
      $display("%0t: now_banned exp %0d got %0d", $time, want.now_banned, got.now_banned);
      errors++;
    end
  endfunction
endclass

// ===== tb/tb.sv =====
// Top-level testbench of the rate limiter: clock, reset, APB writes, request and
// response drivers. Depends on swrl_pkg, swrl_if, swrl_scoreboard and sliding_window_rate_limiter_core.
`timescale 1ns / 100ps

module tb;
  import swrl_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int STALL_CYCLES    = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  swrl_req_if req_if ();
  swrl_rsp_if rsp_if ();

  sliding_window_rate_limiter_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swrl_scoreboard sb;
  logic [31:0] clk_now[16];  // per-client time, kept non-decreasing mostly
  bit    hold_off;           // long receiver stall requested by the sender
  int    idle_cycles;
  int    sent;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Note requests and check responses at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (req_if.valid && req_if.ready) begin
        sb.note_request(req_if.op, req_if.client, req_if.time_ms);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_response({rsp_if.accepted, rsp_if.status, rsp_if.ops_in_minute,
                           rsp_if.now_banned});
      end
      if (idle_cycles > WATCHDOG_CYCLES) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure per response, plus one long hold-off.
  initial begin
    int wait_n;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        rsp_if.ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (wait_n > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (wait_n - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      // hold ready until a response is taken
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  task automatic apb_write(input reg_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_PSL:      sb.psl = value[6:0];
      REG_PML:      sb.pml = value[6:0];
      REG_BAN_LEN:  sb.ban_len = value[26:0];
      default:      sb.thr = value[7:0];
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input int psl_v, input int pml_v, input int ban_v,
                           input int thr_v);
    apb_write(REG_PSL, psl_v);
    apb_write(REG_PML, pml_v);
    apb_write(REG_BAN_LEN, ban_v);
    apb_write(REG_VIOL_THR, thr_v);
  endtask

  // Offer one request after a gap drawn at random, none when no_gap is set; valid held until taken.
  task automatic send(input logic op, input logic [3:0] client, input logic [31:0] t_ms,
                      input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.client <= client;
    req_if.time_ms <= t_ms;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    @(negedge clk_i);
    sent++;
  endtask

  // Drain outstanding responses, then let the back end settle.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_rsp.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // Move a client's clock, mostly in small forward steps, so windows fill and expire.
  task automatic random_item(input int clients, input bit no_gap);
    logic [3:0] c;
    int step;
    c = 4'($urandom_range(0, clients - 1));
    case ($urandom_range(0, 9))
      0:       step = $urandom_range(0, 70000);
      1:       step = -$urandom_range(0, 2000);  // out-of-order time
      2, 3, 4: step = 0;
      default: step = $urandom_range(0, 300);
    endcase
    if ($urandom_range(0, 99) == 0) clk_now[c] = $urandom;
    else clk_now[c] = clk_now[c] + step;
    send(($urandom_range(0, 11) == 0) ? OP_VIOL : OP_CHECK, c, clk_now[c], no_gap);
  endtask

  initial begin
    sb = new();
    sb.clear();
    hold_off = 1'b0;
    idle_cycles = 0;
    sent = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.op = OP_CHECK;
    req_if.client = '0;
    req_if.time_ms = '0;
    foreach (clk_now[i]) clk_now[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extreme fields, both operations, ban expiry and wrap of time.
    send(OP_CHECK, 4'd0, 32'h0000_0000, 0);
    send(OP_CHECK, 4'd15, 32'hFFFF_FFFF, 0);
    send(OP_CHECK, 4'd15, 32'h0000_0100, 0);    // wraps past 2^32
    send(OP_CHECK, 4'd15, 32'h0000_0100, 0);
    send(OP_CHECK, 4'd15, 32'h0000_0050, 0);    // time goes backward
    for (int i = 0; i < 5; i++) send(OP_VIOL, 4'd3, 32'd1000, 0);
    send(OP_CHECK, 4'd3, 32'd2000, 0);          // still banned
    send(OP_VIOL, 4'd3, 32'd3000, 0);
    send(OP_CHECK, 4'd3, 32'd1000 + 32'd300000 + 32'd3000, 0);  // ban lifted
    for (int i = 0; i < 11; i++) send(OP_CHECK, 4'd5, 32'd5000, 1);  // per-second
    drain();

    // Zero limits and tight settings.
    configure(0, 0, 0, 0);
    send(OP_CHECK, 4'd7, 32'd10, 0);
    drain();
    apb_write(REG_PSL, 64);
    send(OP_CHECK, 4'd7, 32'd20, 0);            // per-minute zero
    send(OP_VIOL, 4'd8, 32'd30, 0);             // threshold zero, ban length zero
    send(OP_CHECK, 4'd8, 32'd30, 0);
    drain();

    // Random phases over several settings, extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(10, 60, 300000, 5);
        1: configure(64, 64, 86400000, 255);
        2: configure(1, 1, 0, 1);
        3: configure(3, 127, 5000, 2);
        4: configure($urandom_range(1, 64), $urandom_range(1, 64),
                     $urandom_range(0, 86400000), $urandom_range(1, 255));
        default: configure(64, 64, 2000, 3);
      endcase
      for (int n = 0; n < 300; n++) begin
        if (ph == 1 && n == 50) hold_off = 1'b1;
        random_item((ph == 1) ? 2 : 16, (ph == 1 && n >= 50 && n < 60) || n % 97 < 10);
      end
      drain();
    end

    $display("Sent %0d requests across reset values, zero limits and six random phases;",
             sent);
    $display("%0d responses checked.", sb.checked);
    $display("Status mix ok/ban/sec/min/viol: %0d/%0d/%0d/%0d/%0d", sb.status_seen[0],
             sb.status_seen[1], sb.status_seen[2], sb.status_seen[3], sb.status_seen[4]);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
